### rtl/core/ckf_pkg.sv
package ckf_pkg;

  localparam int NUM_JOINTS = 4;
  localparam int IO_W       = 32;
  localparam int TS_W       = 32;
  localparam int Q_W        = 32;
  localparam int R_W        = 40;
  localparam int CFG_W      = 40;
  localparam int CFG_IDX_W  = 3;
  localparam int ST_W       = 48;
  localparam int FR_W       = 40;
  localparam int MUL_W      = 64;

  localparam logic [ST_W-1:0] CMAX  = '1;
  localparam logic [ST_W-1:0] MAG47 = 48'h8000_0000_0000;
  localparam logic [ST_W-1:0] ONE40 = 48'h0100_0000_0000;

  localparam logic signed [49:0] S48MAX = 50'sd140737488355327;
  localparam logic signed [49:0] S48MIN = -50'sd140737488355328;
  localparam logic signed [47:0] S32MAX = 48'sd2147483647;
  localparam logic signed [47:0] S32MIN = -48'sd2147483648;

  localparam logic [TS_W-1:0] TS_RST  = 32'd42949673;
  localparam logic [Q_W-1:0]  Q_RST   = 32'd6553600;
  localparam logic [R_W-1:0]  R_RST   = 40'd109951163;
  localparam logic [R_W-1:0]  COV_RST = 40'd10995116278;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_STEP_TIME,
    REG_ACCEL_NOISE,
    REG_MEAS_NOISE,
    REG_START_COV,
    REG_START_POS_A,
    REG_START_POS_B,
    REG_START_POS_C,
    REG_START_POS_D
  } cfg_reg_t;

  typedef enum logic [1:0] {SH16, SH24, SH32, SH40} sh_t;

  typedef enum logic [2:0] {
    N_IDLE, N_TS2, N_TS3, N_TS4, N_Q4, N_Q3, N_Q2
  } noise_st_t;

  typedef enum logic [3:0] {
    L_IDLE, L_PRED, L_TPV, L_TVV2, L_TVV, L_DIV, L_CORP, L_CORV, L_UPP, L_UPV, L_UVV
  } lane_st_t;

  typedef enum logic [1:0] {T_IDLE, T_NOISE, T_LANES, T_OUT} top_st_t;

  typedef struct packed {
    logic [FR_W-1:0] ts2;
    logic [ST_W-1:0] q4;
    logic [ST_W-1:0] q3;
    logic [ST_W-1:0] q2;
  } noise_t;

  typedef struct packed {
    logic [TS_W-1:0] ts;
    logic [FR_W-1:0] ts2;
    logic [ST_W-1:0] q4;
    logic [ST_W-1:0] q3;
    logic [ST_W-1:0] q2;
    logic [R_W-1:0]  r;
  } lane_cfg_t;

  function automatic logic [ST_W-1:0] cmin(input logic [MUL_W-1:0] v);
    cmin = (v > {16'd0, CMAX}) ? CMAX : v[ST_W-1:0];
  endfunction

  function automatic logic [ST_W-1:0] cadd(input logic [ST_W-1:0] a, input logic [ST_W-1:0] b);
    logic [ST_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    cadd = s[ST_W] ? CMAX : s[ST_W-1:0];
  endfunction

  function automatic logic [ST_W-1:0] csub(input logic [ST_W-1:0] a, input logic [ST_W-1:0] b);
    csub = (b > a) ? '0 : a - b;
  endfunction

  // truncated magnitude, capped at 2^47, with sign applied
  function automatic logic signed [48:0] smag(input logic [MUL_W-1:0] p, input logic neg);
    logic [ST_W-1:0] m;
    m = (p > {16'd0, MAG47}) ? MAG47 : p[ST_W-1:0];
    smag = neg ? -$signed({1'b0, m}) : $signed({1'b0, m});
  endfunction

  function automatic logic signed [47:0] sat48(input logic signed [49:0] v);
    if (v > S48MAX) sat48 = S48MAX[47:0];
    else if (v < S48MIN) sat48 = S48MIN[47:0];
    else sat48 = v[47:0];
  endfunction

  function automatic logic [IO_W-1:0] sat32(input logic signed [47:0] v);
    if (v > S32MAX) sat32 = S32MAX[IO_W-1:0];
    else if (v < S32MIN) sat32 = S32MIN[IO_W-1:0];
    else sat32 = v[IO_W-1:0];
  endfunction

  function automatic logic [IO_W-1:0] start_pos(input int j);
    case (j)
      0: start_pos = 32'd11391814;
      1: start_pos = 32'd11881104;
      2: start_pos = 32'd11480615;
      3: start_pos = 32'd10689519;
      default: start_pos = '0;
    endcase
  endfunction

endpackage

### rtl/core/ckf_in_if.sv
interface ckf_in_if;
  import ckf_pkg::*;
  logic            valid;
  logic            ready;
  logic [IO_W-1:0] meas_a;
  logic [IO_W-1:0] meas_b;
  logic [IO_W-1:0] meas_c;
  logic [IO_W-1:0] meas_d;
  modport source (output valid, meas_a, meas_b, meas_c, meas_d, input ready);
  modport sink (input valid, meas_a, meas_b, meas_c, meas_d, output ready);
endinterface

### rtl/core/ckf_out_if.sv
interface ckf_out_if;
  import ckf_pkg::*;
  logic            valid;
  logic            ready;
  logic [IO_W-1:0] filt_pos_a;
  logic [IO_W-1:0] filt_pos_b;
  logic [IO_W-1:0] filt_pos_c;
  logic [IO_W-1:0] filt_pos_d;
  logic [IO_W-1:0] filt_vel_a;
  logic [IO_W-1:0] filt_vel_b;
  logic [IO_W-1:0] filt_vel_c;
  logic [IO_W-1:0] filt_vel_d;
  modport source (output valid, filt_pos_a, filt_pos_b, filt_pos_c, filt_pos_d,
                  filt_vel_a, filt_vel_b, filt_vel_c, filt_vel_d, input ready);
  modport sink (input valid, filt_pos_a, filt_pos_b, filt_pos_c, filt_pos_d,
                filt_vel_a, filt_vel_b, filt_vel_c, filt_vel_d, output ready);
endinterface

### rtl/core/constant_velocity_kalman_filter_unit.sv
// The unit takes one input word at a time: a new word is accepted only after the
// previous result word has been loaded for output. Six noise multiplies, then per
// lane nine multiplies on a 4-pass 32x32 multiplier and a bit-serial gain
// division (88 quotient bits) make up the work for each word.
// Reset (rst_n low, synchronous): registers return to defaults, estimates to
// start positions with zero velocity, covariance diagonal to its start value.
module constant_velocity_kalman_filter_unit (
  input  logic                          clk,
  input  logic                          rst_n,
  ckf_in_if.sink                        in_if,
  ckf_out_if.source                     out_if,
  input  logic                          cfg_we,
  input  logic [ckf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [ckf_pkg::CFG_W-1:0]     cfg_data
);
  import ckf_pkg::*;

  top_st_t         st_r, st_nxt;
  logic [TS_W-1:0] ts_r;
  logic [Q_W-1:0]  q_r;
  logic [R_W-1:0]  r_r;
  logic [IO_W-1:0] meas_r [NUM_JOINTS];
  logic [IO_W-1:0] pos_r [NUM_JOINTS];
  logic [IO_W-1:0] vel_r [NUM_JOINTS];
  logic [IO_W-1:0] lane_pos [NUM_JOINTS];
  logic [IO_W-1:0] lane_vel [NUM_JOINTS];
  logic [NUM_JOINTS-1:0] lane_done;
  logic            out_valid_r;
  logic            in_acc, noise_start, noise_done, lane_start, out_load;
  noise_t          nz;
  lane_cfg_t       lcfg;

  ckf_noise u_noise (
    .clk   (clk),
    .rst_n (rst_n),
    .start (noise_start),
    .ts    (ts_r),
    .q     (q_r),
    .done  (noise_done),
    .nz    (nz)
  );

  assign lcfg.ts  = ts_r;
  assign lcfg.ts2 = nz.ts2;
  assign lcfg.q4  = nz.q4;
  assign lcfg.q3  = nz.q3;
  assign lcfg.q2  = nz.q2;
  assign lcfg.r   = r_r;

  for (genvar j = 0; j < NUM_JOINTS; j++) begin : g_lane
    ckf_lane u_lane (
      .clk     (clk),
      .rst_n   (rst_n),
      .start   (lane_start),
      .meas    (meas_r[j]),
      .rst_pos (start_pos(j)),
      .cfg     (lcfg),
      .done    (lane_done[j]),
      .pos     (lane_pos[j]),
      .vel     (lane_vel[j])
    );
  end

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      T_IDLE:  if (in_if.valid) st_nxt = T_NOISE;
      T_NOISE: if (noise_done) st_nxt = T_LANES;
      T_LANES: if (&lane_done) st_nxt = T_OUT;
      T_OUT:   if (!out_valid_r || out_if.ready) st_nxt = T_IDLE;
    endcase
  end

  always_comb begin
    in_if.ready = (st_r == T_IDLE);
    in_acc      = (st_r == T_IDLE) && in_if.valid;
    noise_start = in_acc;
    lane_start  = (st_r == T_NOISE) && noise_done;
    out_load    = (st_r == T_OUT) && (!out_valid_r || out_if.ready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= T_IDLE;
      out_valid_r <= 1'b0;
      ts_r        <= TS_RST;
      q_r         <= Q_RST;
      r_r         <= R_RST;
    end else begin
      st_r <= st_nxt;
      if (cfg_we) begin
        unique case (cfg_reg_t'(cfg_index))
          REG_STEP_TIME:   ts_r <= cfg_data[TS_W-1:0];
          REG_ACCEL_NOISE: q_r  <= cfg_data[Q_W-1:0];
          REG_MEAS_NOISE:  r_r  <= cfg_data[R_W-1:0];
          // start values only matter at reset, which restores the defaults
          REG_START_COV, REG_START_POS_A, REG_START_POS_B,
          REG_START_POS_C, REG_START_POS_D: ;
        endcase
      end
      if (out_load) out_valid_r <= 1'b1;
      else if (out_if.ready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      meas_r[0] <= in_if.meas_a;
      meas_r[1] <= in_if.meas_b;
      meas_r[2] <= in_if.meas_c;
      meas_r[3] <= in_if.meas_d;
    end
    if (out_load) begin
      pos_r <= lane_pos;
      vel_r <= lane_vel;
    end
  end

  assign out_if.valid      = out_valid_r;
  assign out_if.filt_pos_a = pos_r[0];
  assign out_if.filt_pos_b = pos_r[1];
  assign out_if.filt_pos_c = pos_r[2];
  assign out_if.filt_pos_d = pos_r[3];
  assign out_if.filt_vel_a = vel_r[0];
  assign out_if.filt_vel_b = vel_r[1];
  assign out_if.filt_vel_c = vel_r[2];
  assign out_if.filt_vel_d = vel_r[3];

endmodule

### rtl/core/ckf_mul.sv
module ckf_mul (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [ckf_pkg::MUL_W-1:0]  a,
  input  logic [ckf_pkg::MUL_W-1:0]  b,
  input  ckf_pkg::sh_t               sh,
  output logic                       done,
  output logic [ckf_pkg::MUL_W-1:0]  res
);
  import ckf_pkg::*;

  logic [MUL_W-1:0]   a_r, b_r;
  sh_t                sh_r;
  logic [2:0]         cnt_r;
  logic               busy_r, ppv_r, done_r;
  logic [1:0]         sel_r;
  logic [MUL_W-1:0]   pp_r;
  logic [2*MUL_W-1:0] acc_r, pp_ext, shf;
  logic [31:0]        ah, bh;

  // four 32x32 partial products, one per cycle
  always_comb begin
    ah = cnt_r[1] ? a_r[63:32] : a_r[31:0];
    bh = cnt_r[0] ? b_r[63:32] : b_r[31:0];
    unique case (sel_r)
      2'b00:        pp_ext = {64'd0, pp_r};
      2'b01, 2'b10: pp_ext = {32'd0, pp_r, 32'd0};
      2'b11:        pp_ext = {pp_r, 64'd0};
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      ppv_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (ppv_r) acc_r <= acc_r + pp_ext;
      if (start) begin
        busy_r <= 1'b1;
        ppv_r  <= 1'b0;
        cnt_r  <= '0;
        acc_r  <= '0;
        a_r    <= a;
        b_r    <= b;
        sh_r   <= sh;
      end else if (busy_r) begin
        if (cnt_r[2]) begin
          busy_r <= 1'b0;
          ppv_r  <= 1'b0;
          done_r <= 1'b1;
        end else begin
          pp_r  <= ah * bh;
          sel_r <= cnt_r[1:0];
          ppv_r <= 1'b1;
          cnt_r <= cnt_r + 3'd1;
        end
      end
    end
  end

  always_comb begin
    unique case (sh_r)
      SH16: shf = acc_r >> 16;
      SH24: shf = acc_r >> 24;
      SH32: shf = acc_r >> 32;
      SH40: shf = acc_r >> 40;
    endcase
    res = (|shf[2*MUL_W-1:MUL_W]) ? '1 : shf[MUL_W-1:0];
  end

  assign done = done_r;

endmodule

### rtl/core/ckf_div.sv
module ckf_div (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  input  logic [ckf_pkg::ST_W-1:0] num,
  input  logic [ckf_pkg::ST_W:0]   den,
  input  logic [ckf_pkg::ST_W-1:0] cap,
  output logic                     done,
  output logic [ckf_pkg::ST_W-1:0] quo
);
  import ckf_pkg::*;

  localparam int QW = ST_W + FR_W;
  localparam int CW = $clog2(QW + 1);

  logic [QW-1:0]   q_r;
  logic [ST_W:0]   rem_r, den_r;
  logic [ST_W-1:0] cap_r;
  logic [CW-1:0]   cnt_r;
  logic            busy_r, done_r;
  logic [ST_W+1:0] trial, diff;
  logic            ge;

  // restoring division, one quotient bit per cycle
  always_comb begin
    trial = {rem_r, q_r[QW-1]};
    diff  = trial - {1'b0, den_r};
    ge    = trial >= {1'b0, den_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        q_r    <= {num, {FR_W{1'b0}}};
        rem_r  <= '0;
        den_r  <= den;
        cap_r  <= cap;
      end else if (busy_r) begin
        q_r   <= {q_r[QW-2:0], ge};
        rem_r <= ge ? diff[ST_W:0] : trial[ST_W:0];
        cnt_r <= cnt_r + CW'(1);
        if (cnt_r == CW'(QW - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_comb begin
    if (den_r == '0) quo = '0;
    else if (q_r > {{FR_W{1'b0}}, cap_r}) quo = cap_r;
    else quo = q_r[ST_W-1:0];
  end

  assign done = done_r;

endmodule

### rtl/core/ckf_noise.sv
module ckf_noise (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  input  logic [ckf_pkg::TS_W-1:0] ts,
  input  logic [ckf_pkg::Q_W-1:0]  q,
  output logic                     done,
  output ckf_pkg::noise_t          nz
);
  import ckf_pkg::*;

  noise_st_t        st_r, st_nxt;
  logic             issued_r, done_r;
  logic [FR_W-1:0]  ts2_r, ts3_r, ts4_r;
  logic [ST_W-1:0]  q4_r, q3_r, q2_r;
  logic             mul_start, mul_done;
  logic [MUL_W-1:0] mul_a, mul_b, mul_res;
  sh_t              mul_sh;

  ckf_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .sh    (mul_sh),
    .done  (mul_done),
    .res   (mul_res)
  );

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      N_IDLE: if (start) st_nxt = N_TS2;
      N_TS2:  if (mul_done) st_nxt = N_TS3;
      N_TS3:  if (mul_done) st_nxt = N_TS4;
      N_TS4:  if (mul_done) st_nxt = N_Q4;
      N_Q4:   if (mul_done) st_nxt = N_Q3;
      N_Q3:   if (mul_done) st_nxt = N_Q2;
      N_Q2:   if (mul_done) st_nxt = N_IDLE;
    endcase
  end

  always_comb begin
    mul_start = (st_r != N_IDLE) && !issued_r;
    mul_a     = '0;
    mul_b     = '0;
    mul_sh    = SH16;
    unique case (st_r)
      N_IDLE: ;
      N_TS2: begin
        mul_a  = MUL_W'(ts);
        mul_b  = MUL_W'(ts);
        mul_sh = SH24;
      end
      N_TS3: begin
        mul_a  = MUL_W'(ts2_r);
        mul_b  = MUL_W'(ts);
        mul_sh = SH32;
      end
      N_TS4: begin
        mul_a  = MUL_W'(ts3_r);
        mul_b  = MUL_W'(ts);
        mul_sh = SH32;
      end
      N_Q4: begin
        mul_a = MUL_W'(q);
        mul_b = MUL_W'(ts4_r);
      end
      N_Q3: begin
        mul_a = MUL_W'(q);
        mul_b = MUL_W'(ts3_r);
      end
      N_Q2: begin
        mul_a = MUL_W'(q);
        mul_b = MUL_W'(ts2_r);
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r     <= N_IDLE;
      issued_r <= 1'b0;
      done_r   <= 1'b0;
    end else begin
      st_r   <= st_nxt;
      done_r <= (st_r == N_Q2) && mul_done;
      if (mul_start) issued_r <= 1'b1;
      else if (mul_done) issued_r <= 1'b0;
      if (mul_done) begin
        unique case (st_r)
          N_IDLE: ;
          N_TS2:  ts2_r <= mul_res[FR_W-1:0];
          N_TS3:  ts3_r <= mul_res[FR_W-1:0];
          N_TS4:  ts4_r <= mul_res[FR_W-1:0];
          N_Q4:   q4_r  <= cmin({2'b00, mul_res[MUL_W-1:2]});
          N_Q3:   q3_r  <= cmin({1'b0, mul_res[MUL_W-1:1]});
          N_Q2:   q2_r  <= cmin({1'b0, mul_res[MUL_W-1:1]});
        endcase
      end
    end
  end

  assign done   = done_r;
  assign nz.ts2 = ts2_r;
  assign nz.q4  = q4_r;
  assign nz.q3  = q3_r;
  assign nz.q2  = q2_r;

endmodule

### rtl/core/ckf_lane.sv
module ckf_lane (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  input  logic [ckf_pkg::IO_W-1:0] meas,
  input  logic [ckf_pkg::IO_W-1:0] rst_pos,
  input  ckf_pkg::lane_cfg_t       cfg,
  output logic                     done,
  output logic [ckf_pkg::IO_W-1:0] pos,
  output logic [ckf_pkg::IO_W-1:0] vel
);
  import ckf_pkg::*;

  lane_st_t          st_r, st_nxt;
  logic              issued_r, done_r;
  logic signed [47:0] xp_r, xv_r;
  logic [ST_W-1:0]   ppp_r, ppv_r, pvv_r, npp_r, npv_r, nvv_r, k1_r, k2_r;
  logic signed [48:0] e_r;
  logic              mul_start, mul_done, div_start, k1_done, k2_done, mul_st;
  logic [MUL_W-1:0]  mul_a, mul_b, mul_res;
  sh_t               mul_sh;
  logic [ST_W-1:0]   xv_abs, k1_q, k2_q, cm;
  logic [48:0]       e_abs;
  logic [ST_W:0]     den;
  logic signed [48:0] corr;
  logic signed [47:0] xsel, xnew;

  ckf_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .sh    (mul_sh),
    .done  (mul_done),
    .res   (mul_res)
  );

  ckf_div u_div_k1 (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (npp_r),
    .den   (den),
    .cap   (ONE40),
    .done  (k1_done),
    .quo   (k1_q)
  );

  ckf_div u_div_k2 (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (npv_r),
    .den   (den),
    .cap   (CMAX),
    .done  (k2_done),
    .quo   (k2_q)
  );

  always_comb begin
    xv_abs = xv_r[47] ? ST_W'(-xv_r) : ST_W'(xv_r);
    e_abs  = e_r[48] ? 49'(-e_r) : 49'(e_r);
    den    = {1'b0, npp_r} + {{(ST_W + 1 - R_W){1'b0}}, cfg.r};
    cm     = cmin(mul_res);
    corr   = smag(mul_res, (st_r == L_PRED) ? xv_r[47] : e_r[48]);
    xsel   = (st_r == L_CORV) ? xv_r : xp_r;
    xnew   = sat48($signed({{2{xsel[47]}}, xsel}) + $signed({corr[48], corr}));
  end

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      L_IDLE: if (start) st_nxt = L_PRED;
      L_PRED: if (mul_done) st_nxt = L_TPV;
      L_TPV:  if (mul_done) st_nxt = L_TVV2;
      L_TVV2: if (mul_done) st_nxt = L_TVV;
      L_TVV:  if (mul_done) st_nxt = L_DIV;
      L_DIV:  if (k1_done) st_nxt = L_CORP;
      L_CORP: if (mul_done) st_nxt = L_CORV;
      L_CORV: if (mul_done) st_nxt = L_UPP;
      L_UPP:  if (mul_done) st_nxt = L_UPV;
      L_UPV:  if (mul_done) st_nxt = L_UVV;
      L_UVV:  if (mul_done) st_nxt = L_IDLE;
    endcase
  end

  always_comb begin
    mul_st = 1'b1;
    mul_a  = '0;
    mul_b  = '0;
    mul_sh = SH40;
    unique case (st_r)
      L_IDLE, L_DIV: mul_st = 1'b0;
      L_PRED: begin
        mul_a  = MUL_W'(xv_abs);
        mul_b  = MUL_W'(cfg.ts);
        mul_sh = SH32;
      end
      L_TPV: begin
        mul_a  = MUL_W'(cfg.ts);
        mul_b  = MUL_W'(ppv_r);
        mul_sh = SH32;
      end
      L_TVV2: begin
        mul_a = MUL_W'(cfg.ts2);
        mul_b = MUL_W'(pvv_r);
      end
      L_TVV: begin
        mul_a  = MUL_W'(cfg.ts);
        mul_b  = MUL_W'(pvv_r);
        mul_sh = SH32;
      end
      L_CORP: begin
        mul_a = MUL_W'(e_abs);
        mul_b = MUL_W'(k1_r);
      end
      L_CORV: begin
        mul_a = MUL_W'(e_abs);
        mul_b = MUL_W'(k2_r);
      end
      L_UPP: begin
        mul_a = MUL_W'(k1_r);
        mul_b = MUL_W'(npp_r);
      end
      L_UPV: begin
        mul_a = MUL_W'(k1_r);
        mul_b = MUL_W'(npv_r);
      end
      L_UVV: begin
        mul_a = MUL_W'(k2_r);
        mul_b = MUL_W'(npv_r);
      end
    endcase
    mul_start = mul_st && !issued_r;
    div_start = (st_r == L_DIV) && !issued_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r     <= L_IDLE;
      issued_r <= 1'b0;
      done_r   <= 1'b0;
      xp_r     <= $signed({{(ST_W - IO_W){rst_pos[IO_W-1]}}, rst_pos});
      xv_r     <= '0;
      ppp_r    <= {{(ST_W - R_W){1'b0}}, COV_RST};
      ppv_r    <= '0;
      pvv_r    <= {{(ST_W - R_W){1'b0}}, COV_RST};
    end else begin
      st_r   <= st_nxt;
      done_r <= (st_r == L_UVV) && mul_done;
      if (mul_start || div_start) issued_r <= 1'b1;
      else if (mul_done || k1_done) issued_r <= 1'b0;
      if (div_start) begin
        e_r <= $signed({{17{meas[IO_W-1]}}, meas}) - $signed({xp_r[47], xp_r});
      end
      if (k1_done && k2_done) begin
        k1_r <= k1_q;
        k2_r <= k2_q;
      end
      if (mul_done) begin
        unique case (st_r)
          L_IDLE, L_DIV: ;
          L_PRED: xp_r <= xnew;
          L_TPV:  npp_r <= cadd(cadd(ppp_r, cm), cm);
          L_TVV2: npp_r <= cadd(cadd(npp_r, cm), cfg.q4);
          L_TVV: begin
            npv_r <= cadd(cadd(ppv_r, cm), cfg.q3);
            nvv_r <= cadd(pvv_r, cfg.q2);
          end
          L_CORP: xp_r  <= xnew;
          L_CORV: xv_r  <= xnew;
          L_UPP:  ppp_r <= csub(npp_r, cm);
          L_UPV:  ppv_r <= csub(npv_r, cm);
          L_UVV:  pvv_r <= csub(nvv_r, cm);
        endcase
      end
    end
  end

  assign done = done_r;
  assign pos  = sat32(xp_r);
  assign vel  = sat32(xv_r);

endmodule

### rtl/core/ckf_checker.sv
module ckf_sva (
  input logic                     clk,
  input logic                     rst_n,
  input logic                     in_valid,
  input logic                     in_ready,
  input logic                     out_valid,
  input logic                     out_ready,
  input logic [ckf_pkg::IO_W-1:0] out_pos,
  input logic [ckf_pkg::IO_W-1:0] out_vel
);

  a_reset_state: assert property (@(posedge clk)
    !rst_n |=> !out_valid && in_ready)
    else $error("not idle after reset");

  a_one_word: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second word taken while busy");

  a_no_early_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !$rose(out_valid))
    else $error("result right after accept");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_pos) && $stable(out_vel))
    else $error("stalled result word changed");

endmodule

bind constant_velocity_kalman_filter_unit ckf_sva u_ckf_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_if.valid),
  .in_ready  (in_if.ready),
  .out_valid (out_if.valid),
  .out_ready (out_if.ready),
  .out_pos   (out_if.filt_pos_a),
  .out_vel   (out_if.filt_vel_a)
);

### verif/ckf_checker.sv
`timescale 1ns / 100ps

module ckf_checker (
  input  logic                          clk,
  input  logic                          rst_n,
  ckf_in_if                             in_ch,
  ckf_out_if                            out_ch,
  input  logic                          cfg_we,
  input  logic [ckf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [ckf_pkg::CFG_W-1:0]     cfg_data,
  output int                            fail_count,
  output int                            pending
);

  localparam logic [63:0] COV_CAP = 64'h0000_FFFF_FFFF_FFFF;
  localparam logic [63:0] MAG_CAP = 64'h0000_8000_0000_0000;
  localparam logic [63:0] UNITY   = 64'h0000_0100_0000_0000;
  localparam longint      EST_MAX = 64'sh0000_7FFF_FFFF_FFFF;
  localparam longint      EST_MIN = -EST_MAX - 1;

  typedef logic [7:0][31:0] filt_word_t;

  string field_name [8] = '{"filt_pos_a", "filt_pos_b", "filt_pos_c", "filt_pos_d",
                            "filt_vel_a", "filt_vel_b", "filt_vel_c", "filt_vel_d"};

  logic [63:0] step_time, accel_noise, meas_noise, init_cov;
  longint      init_pos [4];
  longint      est_pos [4];
  longint      est_vel [4];
  logic [63:0] cov_pp [4];
  logic [63:0] cov_pv [4];
  logic [63:0] cov_vv [4];
  filt_word_t  filt_expected [$];

  assign pending = filt_expected.size();

  function automatic logic [63:0] mul_shr(logic [63:0] a, logic [63:0] b, int sh);
    logic [127:0] p;
    p = ({64'd0, a} * {64'd0, b}) >> sh;
    return (p[127:64] != 0) ? '1 : p[63:0];
  endfunction

  function automatic logic [63:0] clamp_cov(logic [63:0] v);
    return (v > COV_CAP) ? COV_CAP : v;
  endfunction

  function automatic logic [63:0] add_cov(logic [63:0] a, logic [63:0] b);
    return clamp_cov(a + b);
  endfunction

  function automatic logic [63:0] sub_cov(logic [63:0] a, logic [63:0] b);
    return (b > a) ? 64'd0 : a - b;
  endfunction

  function automatic longint clamp_est(longint v);
    if (v > EST_MAX) return EST_MAX;
    if (v < EST_MIN) return EST_MIN;
    return v;
  endfunction

  function automatic longint scale_signed(longint a, logic [63:0] b, int sh);
    logic [63:0] m, p;
    m = (a < 0) ? 64'd0 - a : a;
    p = mul_shr(m, b, sh);
    if (p > MAG_CAP) p = MAG_CAP;
    return (a < 0) ? -longint'(p) : longint'(p);
  endfunction

  function automatic logic [63:0] gain_div(logic [63:0] n, logic [63:0] d, logic [63:0] cap);
    logic [63:0] q, r;
    if (d == 0) return 0;
    q = n / d;
    r = n % d;
    for (int i = 0; i < 40; i++) begin
      if (q > cap) return cap;
      q = q << 1;
      r = r << 1;
      if (r >= d) begin
        r = r - d;
        q[0] = 1'b1;
      end
    end
    return (q > cap) ? cap : q;
  endfunction

  function automatic logic [31:0] clamp_io(longint v);
    if (v > 64'sd2147483647) return 32'h7FFF_FFFF;
    if (v < -64'sd2147483648) return 32'h8000_0000;
    return v[31:0];
  endfunction

  function automatic filt_word_t filter_step(logic [3:0][31:0] meas);
    filt_word_t  res;
    logic [63:0] ts, ts2, ts3, ts4, q4, q3, q2, tpv, npp, npv, nvv, s, k1, k2;
    longint      xp, xv, e;
    ts  = step_time;
    ts2 = mul_shr(ts, ts, 24);
    ts3 = mul_shr(ts2, ts, 32);
    ts4 = mul_shr(ts3, ts, 32);
    q4  = clamp_cov(mul_shr(accel_noise, ts4, 16) >> 2);
    q3  = clamp_cov(mul_shr(accel_noise, ts3, 16) >> 1);
    q2  = clamp_cov(mul_shr(accel_noise, ts2, 16) >> 1);
    for (int j = 0; j < 4; j++) begin
      xv  = est_vel[j];
      xp  = clamp_est(est_pos[j] + scale_signed(xv, ts, 32));
      tpv = clamp_cov(mul_shr(ts, cov_pv[j], 32));
      npp = add_cov(add_cov(add_cov(add_cov(cov_pp[j], tpv), tpv),
                            clamp_cov(mul_shr(ts2, cov_vv[j], 40))), q4);
      npv = add_cov(add_cov(cov_pv[j], clamp_cov(mul_shr(ts, cov_vv[j], 32))), q3);
      nvv = add_cov(cov_vv[j], q2);
      s   = npp + meas_noise;
      k1  = gain_div(npp, s, UNITY);
      k2  = gain_div(npv, s, COV_CAP);
      e   = longint'($signed(meas[j])) - xp;
      xp  = clamp_est(xp + scale_signed(e, k1, 40));
      xv  = clamp_est(xv + scale_signed(e, k2, 40));
      est_pos[j] = xp;
      est_vel[j] = xv;
      cov_pp[j]  = sub_cov(npp, clamp_cov(mul_shr(k1, npp, 40)));
      cov_pv[j]  = sub_cov(npv, clamp_cov(mul_shr(k1, npv, 40)));
      cov_vv[j]  = sub_cov(nvv, clamp_cov(mul_shr(k2, npv, 40)));
      res[j]     = clamp_io(xp);
      res[4 + j] = clamp_io(xv);
    end
    return res;
  endfunction

  always @(posedge clk) begin
    filt_word_t got, want;
    if (!rst_n) begin
      step_time   = ckf_pkg::TS_RST;
      accel_noise = ckf_pkg::Q_RST;
      meas_noise  = ckf_pkg::R_RST;
      init_cov    = ckf_pkg::COV_RST;
      init_pos    = '{64'sd11391814, 64'sd11881104, 64'sd11480615, 64'sd10689519};
      for (int j = 0; j < 4; j++) begin
        est_pos[j] = init_pos[j];
        est_vel[j] = 0;
        cov_pp[j]  = init_cov;
        cov_pv[j]  = 0;
        cov_vv[j]  = init_cov;
      end
      filt_expected.delete();
      fail_count = 0;
    end else begin
      if (cfg_we) begin
        case (ckf_pkg::cfg_reg_t'(cfg_index))
          ckf_pkg::REG_STEP_TIME:   step_time   = cfg_data[31:0];
          ckf_pkg::REG_ACCEL_NOISE: accel_noise = cfg_data[31:0];
          ckf_pkg::REG_MEAS_NOISE:  meas_noise  = cfg_data;
          ckf_pkg::REG_START_COV:   init_cov    = cfg_data;
          default: init_pos[cfg_index - ckf_pkg::REG_START_POS_A] =
                     longint'($signed(cfg_data[31:0]));
        endcase
      end
      if (out_ch.valid && out_ch.ready) begin
        got = {out_ch.filt_vel_d, out_ch.filt_vel_c, out_ch.filt_vel_b, out_ch.filt_vel_a,
               out_ch.filt_pos_d, out_ch.filt_pos_c, out_ch.filt_pos_b, out_ch.filt_pos_a};
        if (filt_expected.size() == 0) begin
          $error("unexpected output word %h", got);
          fail_count++;
        end else begin
          want = filt_expected.pop_front();
          for (int f = 0; f < 8; f++)
            if (got[f] !== want[f]) begin
              $error("%s expected %h actual %h", field_name[f], want[f], got[f]);
              fail_count++;
            end
        end
      end
      if (in_ch.valid && in_ch.ready)
        filt_expected.push_back(filter_step({in_ch.meas_d, in_ch.meas_c,
                                             in_ch.meas_b, in_ch.meas_a}));
    end
  end

endmodule

### verif/tb.sv
`timescale 1ns / 100ps

module tb;

  localparam int IDLE_LIMIT = 20000;
  localparam int DRAIN      = 300;

  logic                          clk;
  logic                          rst_n;
  logic                          cfg_we;
  logic [ckf_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [ckf_pkg::CFG_W-1:0]     cfg_data;
  int                            fail_count, pending, sent, idle_cycles;
  int                            burst_left;
  bit                            hold_off;
  int                            traj_pos [4];
  int                            traj_vel [4];

  ckf_in_if  in_ch ();
  ckf_out_if out_ch ();

  constant_velocity_kalman_filter_unit dut (
    .clk(clk), .rst_n(rst_n), .in_if(in_ch), .out_if(out_ch),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  ckf_checker chk (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .fail_count(fail_count), .pending(pending)
  );

  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  initial begin
    int phase;
    phase = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      phase++;
      if (hold_off) out_ch.ready = 1'b0;
      else case ((phase / 64) % 4)
        0: out_ch.ready = 1'b1;
        1: out_ch.ready = ($urandom_range(0, 1) == 0);
        2: out_ch.ready = ($urandom_range(0, 3) == 0);
        default: out_ch.ready = ($urandom_range(0, 7) != 0);
      endcase
    end
  end

  initial begin
    hold_off = 1'b0;
    wait (sent >= 400);
    @(negedge clk);
    hold_off = 1'b1;
    repeat (900) @(negedge clk);
    hold_off = 1'b0;
  end

  task automatic write_reg(ckf_pkg::cfg_reg_t idx, logic [39:0] value);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = value;
    @(negedge clk);
  endtask

  task automatic settle_and_configure(logic [31:0] ts, logic [31:0] q, logic [39:0] r);
    in_ch.valid = 1'b0;
    wait (pending == 0);
    repeat (DRAIN) @(negedge clk);
    write_reg(ckf_pkg::REG_STEP_TIME, {8'd0, ts});
    write_reg(ckf_pkg::REG_ACCEL_NOISE, {8'd0, q});
    write_reg(ckf_pkg::REG_MEAS_NOISE, r);
    write_reg(ckf_pkg::REG_START_COV, 40'({$urandom, $urandom}));
    write_reg(ckf_pkg::REG_START_POS_A, {8'd0, $urandom});
    write_reg(ckf_pkg::REG_START_POS_B, {8'd0, $urandom});
    write_reg(ckf_pkg::REG_START_POS_C, {8'd0, $urandom});
    write_reg(ckf_pkg::REG_START_POS_D, {8'd0, $urandom});
    cfg_we = 1'b0;
  endtask

  task automatic send_meas(logic [31:0] a, logic [31:0] b, logic [31:0] c, logic [31:0] d);
    in_ch.meas_a = a;
    in_ch.meas_b = b;
    in_ch.meas_c = c;
    in_ch.meas_d = d;
    in_ch.valid  = 1'b1;
    do @(posedge clk); while (!in_ch.ready);
    sent++;
    @(negedge clk);
    if (burst_left == 0) begin
      in_ch.valid = 1'b0;
      repeat ($urandom_range(0, 15)) @(negedge clk);
      burst_left = $urandom_range(0, 2) == 0 ? 40 : $urandom_range(1, 8);
    end else begin
      burst_left--;
    end
  endtask

  function automatic logic [31:0] joint_sample(int j);
    if ($urandom_range(0, 99) < 12) return $urandom;
    if ($urandom_range(0, 49) == 0) traj_vel[j] = $signed($urandom_range(0, 1 << 20)) - (1 << 19);
    traj_pos[j] += traj_vel[j];
    return traj_pos[j] + $signed($urandom_range(0, 1 << 14)) - (1 << 13);
  endfunction

  initial begin
    logic [31:0] ts, q;
    logic [39:0] r;
    rst_n        = 1'b0;
    cfg_we       = 1'b0;
    cfg_index    = '0;
    cfg_data     = '0;
    in_ch.valid  = 1'b0;
    in_ch.meas_a = '0;
    in_ch.meas_b = '0;
    in_ch.meas_c = '0;
    in_ch.meas_d = '0;
    sent         = 0;
    burst_left   = 3;
    for (int j = 0; j < 4; j++) begin
      traj_pos[j] = 11000000;
      traj_vel[j] = 0;
    end
    repeat (9) @(negedge clk);
    rst_n = 1'b1;

    // defaults, extreme measurements
    send_meas(32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000, 32'hFFFF_FFFF);
    send_meas(32'h8000_0000, 32'h7FFF_FFFF, 32'h00A0_0000, 32'h0000_0001);
    send_meas(32'h00AD_D346, 32'h00B5_4A90, 32'h00AF_2D27, 32'h00A3_1BEF);
    // no noise and no motion drive the divisor to zero
    settle_and_configure(32'd0, 32'd0, 40'd0);
    repeat (5) send_meas($urandom, $urandom, 32'h7FFF_FFFF, 32'h8000_0000);
    // everything at full scale: saturation on estimate and covariance
    settle_and_configure('1, '1, '1);
    send_meas(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000);
    send_meas(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    repeat (4) send_meas($urandom, $urandom, $urandom, $urandom);
    settle_and_configure('1, 32'd0, 40'd0);
    repeat (4) send_meas($urandom, $urandom, $urandom, $urandom);
    settle_and_configure(32'd42949673, 32'd6553600, 40'd109951163);
    repeat (4) send_meas(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);

    for (int p = 0; p < 10; p++) begin
      case ($urandom_range(0, 4))
        0: begin ts = $urandom; q = $urandom; r = 40'({$urandom, $urandom}); end
        1: begin ts = $urandom_range(0, 1 << 27); q = '1; r = 40'd0; end
        2: begin ts = '1; q = $urandom_range(0, 1 << 20); r = '1; end
        default: begin
          ts = $urandom_range(1 << 22, 1 << 27);
          q  = $urandom_range(0, 1 << 24);
          r  = 40'($urandom_range(0, 1 << 30));
        end
      endcase
      settle_and_configure(ts, q, r);
      repeat (168) send_meas(joint_sample(0), joint_sample(1), joint_sample(2),
                             joint_sample(3));
    end

    in_ch.valid = 1'b0;
    wait (pending == 0);
    repeat (DRAIN) @(negedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

### files.f
rtl/core/ckf_pkg.sv
rtl/core/ckf_in_if.sv
rtl/core/ckf_out_if.sv
rtl/core/ckf_mul.sv
rtl/core/ckf_div.sv
rtl/core/ckf_noise.sv
rtl/core/ckf_lane.sv
rtl/core/constant_velocity_kalman_filter_unit.sv
rtl/core/ckf_checker.sv
verif/ckf_checker.sv
verif/tb.sv
